// File: rtl/canonical_kmer_counter_macros.svh
// Assertion macros for the canonical k-mer counter.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CANONICAL_KMER_COUNTER_MACROS_SVH
`define CANONICAL_KMER_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
`define CKC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("canonical_kmer_counter: check failed");
`define CKC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("canonical_kmer_counter: check failed");
`else
`define CKC_ASSERT(lbl, clk, rstn, prop)
`define CKC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/ckc_pkg.sv
// Shared types and constants of the canonical k-mer counter.
// No dependencies.
`default_nettype none
package ckc_pkg;

	typedef enum logic [1:0] {
		ACT_BASE  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 8;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_KMER_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SKIP_COUNT  = 1'b1;

	localparam logic [3:0] KMER_RESET = 4'd5;
	localparam logic [3:0] RUN_MAX    = 4'd15;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_N = 8'h4E;

	// request from the window stage to the count stage
	typedef struct packed {
		logic        inc;
		logic        rd;
		logic        clr;
		logic        counted;
		logic [15:0] canon;
		logic        bad;
	} req_t;

	typedef struct packed {
		logic [31:0] count_value;
		logic        window_counted;
		logic [15:0] canonical_code;
		logic        bad_char;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/ckc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ckc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/ckc_window.sv
// Window stage: config registers, base decode, forward/reverse codes, stride.
// Depends on ckc_pkg.
`default_nettype none
module ckc_window #(
	parameter int MAX_K = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [ckc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [ckc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                 acc,
	input  wire ckc_pkg::action_t                     action,
	input  wire logic [7:0]                           base_char,
	input  wire logic                                 record_start,
	input  wire logic [15:0]                          read_index,
	output      ckc_pkg::req_t                        req,
	output      logic [2*MAX_K-1:0]                   raddr
);

	localparam int CW = 2 * MAX_K;

	logic [3:0]    klen_q;
	logic [7:0]    skip_q;
	logic [CW-1:0] fwd_q, rev_q;
	logic [3:0]    run_q, seen_q;
	logic [7:0]    phase_q;

	logic [3:0]    k_eff;
	logic [4:0]    k2;
	logic [CW-1:0] mask, top_bits;
	logic [1:0]    cls;
	logic          is_acgt, is_n;
	logic [CW-1:0] fwd0, rev0, fwd_n, rev_n, canon;
	logic [3:0]    run0, seen0, run_n, seen_n;
	logic [7:0]    phase0, phase_n;
	logic          full, counted, is_base, upd;
	logic [CW+15:0] canon_x;
	logic [CW+15:0] index_x;

	always_comb begin
		if (klen_q == 4'd0) begin
			k_eff = 4'd1;
		end else if (klen_q > 4'(MAX_K)) begin
			k_eff = 4'(MAX_K);
		end else begin
			k_eff = klen_q;
		end
		k2 = {k_eff, 1'b0};
		for (int i = 0; i < CW; i++) begin
			mask[i] = (5'(i) < k2);
		end

		cls     = 2'd0;
		is_acgt = 1'b1;
		is_n    = 1'b0;
		case (base_char)
			ckc_pkg::CHAR_A: cls = 2'd0;
			ckc_pkg::CHAR_C: cls = 2'd1;
			ckc_pkg::CHAR_G: cls = 2'd2;
			ckc_pkg::CHAR_T: cls = 2'd3;
			ckc_pkg::CHAR_N: begin
				is_acgt = 1'b0;
				is_n    = 1'b1;
			end
			default: is_acgt = 1'b0;
		endcase

		fwd0   = record_start ? '0 : fwd_q;
		rev0   = record_start ? '0 : rev_q;
		run0   = record_start ? 4'd0 : run_q;
		seen0  = record_start ? 4'd0 : seen_q;
		phase0 = record_start ? 8'd0 : phase_q;

		top_bits = CW'(~cls) << (k2 - 5'd2);
		if (is_acgt) begin
			fwd_n = ((fwd0 << 2) | CW'(cls)) & mask;
			rev_n = ((rev0 >> 2) | top_bits) & mask;
			run_n = (run0 == ckc_pkg::RUN_MAX) ? run0 : run0 + 4'd1;
		end else begin
			fwd_n = '0;
			rev_n = '0;
			run_n = 4'd0;
		end
		seen_n = (seen0 == ckc_pkg::RUN_MAX) ? seen0 : seen0 + 4'd1;

		full    = (seen_n >= k_eff);
		phase_n = phase0;
		if (full) begin
			phase_n = (phase0 >= skip_q) ? 8'd0 : phase0 + 8'd1;
		end
		counted = full && (phase0 == 8'd0) && (run_n >= k_eff);
		canon   = (fwd_n < rev_n) ? fwd_n : rev_n;

		is_base = (action == ckc_pkg::ACT_BASE);
		upd     = acc && is_base;

		canon_x = {16'd0, canon};
		index_x = {{CW{1'b0}}, read_index};

		req.inc     = is_base && counted;
		req.rd      = (action == ckc_pkg::ACT_READ);
		req.clr     = (action == ckc_pkg::ACT_CLEAR);
		req.counted = is_base && counted;
		req.canon   = (is_base && counted) ? canon_x[15:0] : 16'd0;
		req.bad     = is_base && !is_acgt && !is_n;
		raddr       = (is_base && counted) ? canon : index_x[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q  <= ckc_pkg::KMER_RESET;
			skip_q  <= 8'd0;
			fwd_q   <= '0;
			rev_q   <= '0;
			run_q   <= 4'd0;
			seen_q  <= 4'd0;
			phase_q <= 8'd0;
		end else begin
			if (cfg_we && cfg_index == ckc_pkg::CFG_KMER_LENGTH) begin
				klen_q <= cfg_data[3:0];
			end else if (cfg_we && cfg_index == ckc_pkg::CFG_SKIP_COUNT) begin
				skip_q <= cfg_data;
			end
			if (upd) begin
				fwd_q   <= fwd_n;
				rev_q   <= rev_n;
				run_q   <= run_n;
				seen_q  <= seen_n;
				phase_q <= phase_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ckc_update.sv
// Count stage: table RAM read-modify-write with forwarding, clear sweep.
// Depends on ckc_pkg, ckc_ram and the assertion macro header.
`default_nettype none
`include "canonical_kmer_counter_macros.svh"
module ckc_update #(
	parameter int MAX_K      = 8,
	parameter int COUNT_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_v,
	input  wire ckc_pkg::req_t      req,
	input  wire logic [2*MAX_K-1:0] raddr,
	output      logic               busy,
	output      logic               res_v,
	output      ckc_pkg::res_t      res
);

	localparam int AW    = 2 * MAX_K;
	localparam int DEPTH = 1 << AW;

	logic                  v_s1, hz_s1;
	ckc_pkg::req_t         ctl_s1;
	logic [AW-1:0]         addr_s1;
	logic [COUNT_BITS-1:0] fwd_q;
	logic                  clr_q;
	logic [AW-1:0]         clr_addr_q;

	logic                  wen_s1, we;
	logic [AW-1:0]         waddr;
	logic [COUNT_BITS-1:0] rdata, cur, nxt, wdata, cv;
	logic [COUNT_BITS+31:0] cv_x;

	ckc_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (req_v),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		wen_s1 = v_s1 && ctl_s1.inc;
		cur    = hz_s1 ? fwd_q : rdata;
		nxt    = (&cur) ? cur : cur + 1'b1;
		we     = clr_q || wen_s1;
		waddr  = clr_q ? clr_addr_q : addr_s1;
		wdata  = clr_q ? '0 : nxt;
		if (ctl_s1.inc) begin
			cv = nxt;
		end else if (ctl_s1.rd) begin
			cv = cur;
		end else begin
			cv = '0;
		end
		cv_x = {32'd0, cv};
		res.count_value    = cv_x[31:0];
		res.window_counted = ctl_s1.counted;
		res.canonical_code = ctl_s1.canon;
		res.bad_char       = ctl_s1.bad;
		res_v              = v_s1;
		busy               = clr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			hz_s1      <= 1'b0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			v_s1 <= req_v;
			if (req_v) begin
				hz_s1 <= wen_s1 && (addr_s1 == raddr);
			end
			if (req_v && req.clr) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_v) begin
			ctl_s1  <= req;
			addr_s1 <= raddr;
		end
		if (wen_s1) begin
			fwd_q <= nxt;
		end
	end

	`CKC_ASSERT(a_no_upd_in_clear, clk, arst_n, !(clr_q && wen_s1))
	`CKC_ASSERT(a_no_req_in_clear, clk, arst_n, !(clr_q && req_v))
	`CKC_ASSERT_IMP(a_fwd_after_write, clk, arst_n, v_s1 && hz_s1, $past(wen_s1))

endmodule
`default_nettype wire

// File: rtl/canonical_kmer_counter.sv
// Canonical k-mer counter, top level: stream ports, window and count stages,
// two-entry result queue. Depends on ckc_pkg, ckc_window, ckc_update, macros.
//
// Usage:
//   Input items arrive on s_axis_*: an action (base in, read count, clear table,
//   no-op), a base character with a record-start flag, or a table index to read.
//   Every accepted item yields exactly one result item on m_axis_*.
//   Configuration (k-mer length, skip count) is written through cfg_we /
//   cfg_index / cfg_data while the block is idle.
//   Each accepted item is registered into the count stage, and its result is then
//   written into the queue, from which it can be taken on m_axis_*.
//   Throughput: one item per cycle while s_axis_tready is high; the table RAM does
//   one read and one write per cycle, forwarding back-to-back hits on one entry.
//   Reset and the clear action start a sweep of all 2^(2*MAX_K) table entries
//   (65536 at the default), one entry per cycle; s_axis_tready is low for the
//   sweep. The clear action's own result is delivered normally.
//   When m_axis_tready is low, results collect in a two-entry queue and
//   s_axis_tready drops once two items wait in the count stage and the queue.
`default_nettype none
`include "canonical_kmer_counter_macros.svh"
module canonical_kmer_counter #(
	parameter int MAX_K      = 8,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ckc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [ckc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	input  wire logic [23:0]                         s_axis_tdata,  // base_char, read_index
	input  wire logic [2:0]                          s_axis_tuser,  // action, record_start
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output      logic [47:0]                         m_axis_tdata,  // count_value, canonical_code
	output      logic [1:0]                          m_axis_tuser   // window_counted, bad_char
);

	ckc_pkg::req_t      req;
	logic [2*MAX_K-1:0] raddr;
	logic               busy, res_v, accept, pop;
	ckc_pkg::res_t      res;
	ckc_pkg::res_t      ent_q [2];
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;

	ckc_window #(
		.MAX_K(MAX_K)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.acc         (accept),
		.action      (ckc_pkg::action_t'(s_axis_tuser[1:0])),
		.base_char   (s_axis_tdata[7:0]),
		.record_start(s_axis_tuser[2]),
		.read_index  (s_axis_tdata[23:8]),
		.req         (req),
		.raddr       (raddr)
	);

	ckc_update #(
		.MAX_K     (MAX_K),
		.COUNT_BITS(COUNT_BITS)
	) u_update (
		.clk   (clk),
		.arst_n(arst_n),
		.req_v (accept),
		.req   (req),
		.raddr (raddr),
		.busy  (busy),
		.res_v (res_v),
		.res   (res)
	);

	always_comb begin
		m_axis_tvalid = (cnt_q != 2'd0);
		pop           = m_axis_tvalid && m_axis_tready;
		// count stage plus queue hold at most two items
		s_axis_tready = !busy && (!(res_v || cnt_q == 2'd2) || (res_v && cnt_q == 2'd0)
			|| pop);
		accept        = s_axis_tvalid && s_axis_tready;
		m_axis_tdata  = {ent_q[rd_q].canonical_code, ent_q[rd_q].count_value};
		m_axis_tuser  = {ent_q[rd_q].bad_char, ent_q[rd_q].window_counted};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_v) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, res_v} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			ent_q[wr_q] <= res;
		end
	end

	`CKC_ASSERT(a_occupancy, clk, arst_n, !(res_v && cnt_q == 2'd2))
	`CKC_ASSERT(a_no_accept_busy, clk, arst_n, !(accept && busy))
	`CKC_ASSERT(a_code_zero, clk, arst_n, !m_axis_tvalid || m_axis_tuser[0] || ~|m_axis_tdata[47:32])

endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench for canonical_kmer_counter: directed and random item streams with a
// built-in k-mer window and count-table predictor, checked field by field.
// Depends on ckc_pkg and the canonical_kmer_counter RTL.
`timescale 1ns / 100ps
module testbench;
	import ckc_pkg::*;

	localparam int KMER_MAX   = 8;
	localparam int STALL_LIMIT = 250000;

	typedef enum logic [2:0] {NT_A, NT_C, NT_G, NT_T, NT_N, NT_BAD} nt_class_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // base_char, read_index
	logic [2:0]  s_axis_tuser = '0;  // action, record_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // count_value, canonical_code
	logic [1:0]  m_axis_tuser;       // window_counted, bad_char

	canonical_kmer_counter #(.MAX_K(KMER_MAX), .COUNT_BITS(32)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [3:0]  cur_k = KMER_RESET;
	logic [7:0]  cur_skip = '0;
	logic [15:0] win_fwd = '0;
	logic [15:0] win_rc = '0;
	logic [3:0]  good_run = '0;
	logic [3:0]  pos_count = '0;
	logic [7:0]  start_phase = '0;
	logic [31:0] kmer_counts [logic [15:0]];
	logic [15:0] last_counted_code = '0;

	res_t pending_results [$];
	res_t want;
	int   err_count = 0;
	int   idle_cycles = 0;
	int   ready_hold = 0;
	bit   idle_en = 1'b1;

	function automatic res_t count_kmer_item(action_t act, logic [7:0] ch, logic rs,
			logic [15:0] idx);
		res_t        r;
		int unsigned k;
		logic [15:0] msk;
		nt_class_t   cls;
		logic        slot;
		logic [15:0] canon;
		r = '0;
		case (act)
			ACT_BASE: begin
				k = (cur_k == 0) ? 1 : ((cur_k > KMER_MAX) ? KMER_MAX : cur_k);
				msk = 16'((32'd1 << (2 * k)) - 1);
				case (ch)
					CHAR_A: cls = NT_A;
					CHAR_C: cls = NT_C;
					CHAR_G: cls = NT_G;
					CHAR_T: cls = NT_T;
					CHAR_N: cls = NT_N;
					default: cls = NT_BAD;
				endcase
				if (rs) begin
					win_fwd = '0;
					win_rc = '0;
					good_run = '0;
					pos_count = '0;
					start_phase = '0;
				end
				r.bad_char = (cls == NT_BAD);
				if (cls < NT_N) begin
					win_fwd = ((win_fwd << 2) | 16'(2'(cls))) & msk;
					win_rc = ((win_rc >> 2) | ((16'd3 - 16'(2'(cls))) << (2 * k - 2))) & msk;
					if (good_run < RUN_MAX) good_run++;
				end else begin
					win_fwd = '0;
					win_rc = '0;
					good_run = '0;
				end
				if (pos_count < RUN_MAX) pos_count++;
				if (pos_count >= k) begin
					slot = (start_phase == 0);
					start_phase = (start_phase >= cur_skip) ? 8'd0 : start_phase + 8'd1;
					if (slot && good_run >= k) begin
						canon = (win_fwd < win_rc) ? win_fwd : win_rc;
						if (!kmer_counts.exists(canon)) kmer_counts[canon] = '0;
						if (kmer_counts[canon] != '1) kmer_counts[canon]++;
						r.count_value = kmer_counts[canon];
						r.window_counted = 1'b1;
						r.canonical_code = canon;
						last_counted_code = canon;
					end
				end
			end
			ACT_READ: r.count_value = kmer_counts.exists(idx) ? kmer_counts[idx] : '0;
			ACT_CLEAR: kmer_counts.delete();
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input action_t act, input logic [7:0] ch, input logic rs,
			input logic [15:0] idx);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {idx, ch};
		s_axis_tuser <= {rs, act};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(count_kmer_item(act, ch, rs, idx));
	endtask

	task automatic send_base(input logic [7:0] ch, input logic rs);
		send_item(ACT_BASE, ch, rs, 16'($urandom));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		wait_drained();
		repeat (4) @(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KMER_LENGTH) cur_k = val[3:0];
		else cur_skip = val;
	endtask

	task automatic set_config(input logic [3:0] k, input logic [7:0] skip);
		write_reg(CFG_KMER_LENGTH, {4'd0, k});
		write_reg(CFG_SKIP_COUNT, skip);
	endtask

	function automatic logic [7:0] pick_base();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return CHAR_A;
				1: return CHAR_C;
				2: return CHAR_G;
				default: return CHAR_T;
			endcase
		end
		if (r < 92) return CHAR_N;
		return 8'($urandom);
	endfunction

	task automatic test_window_basics();
		send_item(ACT_READ, 8'h00, 1'b0, 16'h0000);
		send_base(CHAR_A, 1'b1);
		send_base(CHAR_C, 1'b0);
		send_base(CHAR_G, 1'b0);
		send_base(CHAR_T, 1'b0);
		send_base(CHAR_A, 1'b0);
		send_base(CHAR_C, 1'b0);
		send_base(CHAR_N, 1'b0);
		send_base(8'h61, 1'b0);  // lowercase a
		send_base(8'hFF, 1'b0);
		send_base(8'h00, 1'b0);
		send_item(ACT_NOP, 8'hFF, 1'b1, 16'hFFFF);
		send_item(ACT_READ, 8'hFF, 1'b1, 16'h006C);
		send_item(ACT_READ, 8'h00, 1'b0, 16'hFFFF);
	endtask

	task automatic test_length_extremes();
		set_config(4'd1, 8'd255);
		send_base(CHAR_T, 1'b1);
		send_base(CHAR_A, 1'b0);
		write_reg(CFG_KMER_LENGTH, 8'd0);
		send_base(CHAR_C, 1'b1);
	endtask

	task automatic test_length_change();
		set_config(4'd3, 8'd0);
		send_base(CHAR_A, 1'b1);
		send_base(CHAR_C, 1'b0);
		send_base(CHAR_G, 1'b0);
		write_reg(CFG_KMER_LENGTH, 8'd2);
		send_base(CHAR_T, 1'b0);
	endtask

	task automatic test_table_clear();
		send_item(ACT_CLEAR, 8'hA5, 1'b1, 16'h5A5A);
		send_item(ACT_READ, 8'h00, 1'b0, 16'h006C);
	endtask

	task automatic test_random_stream();
		logic [3:0] ks [8] = '{4'd8, 4'd1, 4'd3, 4'd4, 4'd15, 4'd0, 4'd2, 4'd5};
		logic [7:0] skips [8] = '{8'd0, 8'd0, 8'd2, 8'd1, 8'd3, 8'd255, 8'd7, 8'd0};
		int unsigned r;
		int clears_left;
		clears_left = 2;
		for (int p = 0; p < 8; p++) begin
			set_config(ks[p], skips[p]);
			if (p == 7) idle_en = 1'b0;
			for (int n = 0; n < 62; n++) begin
				if (p == 3 && n == 30) wait_drained();
				r = $urandom_range(0, 99);
				if (r < 80) begin
					send_base(pick_base(), $urandom_range(0, 29) == 0);
				end else if (r < 94) begin
					send_item(ACT_READ, 8'($urandom), 1'($urandom),
						$urandom_range(0, 1) ? last_counted_code : 16'($urandom));
				end else if (r < 97 && clears_left > 0) begin
					clears_left--;
					send_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom));
				end else begin
					send_item(ACT_NOP, 8'($urandom), 1'($urandom), 16'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_basics();
		test_length_extremes();
		test_length_change();
		test_table_clear();
		test_random_stream();
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("[canonical_kmer_counter] OK");
		end else begin
			$display("[canonical_kmer_counter] ERROR");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			ready_hold <= $urandom_range(0, 13);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== want.count_value) begin
					$error("count_value: expected %0d, got %0d",
						want.count_value, m_axis_tdata[31:0]);
					err_count++;
				end
				if (m_axis_tuser[0] !== want.window_counted) begin
					$error("window_counted: expected %0d, got %0d",
						want.window_counted, m_axis_tuser[0]);
					err_count++;
				end
				if (m_axis_tdata[47:32] !== want.canonical_code) begin
					$error("canonical_code: expected %h, got %h",
						want.canonical_code, m_axis_tdata[47:32]);
					err_count++;
				end
				if (m_axis_tuser[1] !== want.bad_char) begin
					$error("bad_char: expected %0d, got %0d",
						want.bad_char, m_axis_tuser[1]);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[canonical_kmer_counter] ERROR");
				$finish;
			end
		end
	end

endmodule

// File: files.f
+incdir+rtl
rtl/ckc_pkg.sv
rtl/ckc_ram.sv
rtl/ckc_window.sv
rtl/ckc_update.sv
rtl/canonical_kmer_counter.sv
test/testbench.sv
